[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the extrapolation table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

[rtl/core/rext_pkg.sv]
// ----------------------------------------------------------------------------
// rext_pkg
// Types and constants shared by the extrapolation table modules.
// ----------------------------------------------------------------------------
package rext_pkg;

  localparam int VAL_W         = 48;  // Q24.24 entry width
  localparam int DIFF_W        = VAL_W + 1;
  localparam int SUM_W         = VAL_W + 2;
  localparam int LVL_W         = 4;   // level counter width
  localparam int OUT_IDX_W     = 3;   // level and column fields on the port
  localparam int DIV_BITS      = 8;   // dividend bits retired per cycle (about)
  localparam int MAX_LEVEL_DEF = 8;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_ABS,
    CS_DIV,
    CS_ADD,
    CS_DONE
  } cell_state_t;

  typedef struct packed {
    logic load;   // capture neighbor value as new previous-row entry
    logic run;    // also compute the next column from it
    logic take;   // result moved to the output register
  } cell_ctl_t;

  typedef struct packed {
    logic done;
    logic sat;
    val_t value;
  } cell_res_t;

endpackage

[rtl/core/rext_if.sv]
// ----------------------------------------------------------------------------
// rext_if
// Valid/ready channels for estimate requests and tableau entries.
// ----------------------------------------------------------------------------
interface rext_in_if import rext_pkg::*; ();
  logic valid;
  logic ready;
  val_t base_estimate;
  logic restart;

  modport source (output valid, output base_estimate, output restart, input ready);
  modport sink   (input valid, input base_estimate, input restart, output ready);
endinterface

interface rext_out_if import rext_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] level;
  logic [OUT_IDX_W-1:0] column;
  val_t                 value;
  logic                 saturated;
  logic                 last;

  modport source (output valid, output level, output column, output value,
                  output saturated, output last, input ready);
  modport sink   (input valid, input level, input column, input value,
                  input saturated, input last, output ready);
endinterface

[rtl/core/rext_cell.sv]
// ----------------------------------------------------------------------------
// rext_cell
// One tableau column: holds previous-row entry, divides by 2^K-1, saturates.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rext_cell import rext_pkg::*; #(
  parameter int K = 1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  val_t      col_in,
  input  cell_ctl_t ctl,
  output cell_res_t res
);

  // Divisor 2^K-1: chunk recurrence over K-bit digits, STEPS digits a cycle.
  localparam int STEPS = (DIV_BITS + K - 1) / K;
  localparam int NCH   = (VAL_W + K - 1) / K;
  localparam int NCYC  = (NCH + STEPS - 1) / STEPS;
  localparam int NUM_W = NCYC * STEPS * K;
  localparam int CNT_W = $clog2(NCYC + 1);
  localparam logic [K-1:0]     DIV      = {K{1'b1}};
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NCYC - 1);

  cell_state_t state_r, state_nxt;

  val_t               prev_r;
  val_t               acc_r;
  logic [DIFF_W-1:0]  diff_r;
  logic               neg_r;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [NUM_W-1:0]   quo_r, quo_nxt;
  logic [K-1:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r;
  val_t               val_r;
  logic               sat_r;

  logic [DIFF_W-1:0]  mag;
  logic [VAL_W-1:0]   quo_mag;
  logic [SUM_W-1:0]   sum;
  logic               ovf;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: if (ctl.load && ctl.run) state_nxt = CS_ABS;
      CS_ABS:  state_nxt = CS_DIV;
      CS_DIV:  if (cnt_r == CNT_LAST) state_nxt = CS_ADD;
      CS_ADD:  state_nxt = CS_DONE;
      CS_DONE: if (ctl.take) state_nxt = CS_IDLE;
      default: state_nxt = CS_IDLE;
    endcase
  end

  // r*2^K + c = r*D + (r + c): digit is r plus one if r + c reaches D.
  always_comb begin
    logic [NUM_W-1:0] num_v;
    logic [NUM_W-1:0] quo_v;
    logic [K-1:0]     rem_v;
    logic [K:0]       t_v;
    logic             ge_v;
    logic [K-1:0]     dig_v;
    num_v = num_r;
    quo_v = quo_r;
    rem_v = rem_r;
    for (int s = 0; s < STEPS; s++) begin
      t_v   = {1'b0, rem_v} + {1'b0, num_v[NUM_W-1 -: K]};
      ge_v  = (t_v >= {1'b0, DIV});
      dig_v = rem_v + K'(ge_v);
      rem_v = ge_v ? (t_v[K-1:0] - DIV) : t_v[K-1:0];
      num_v = num_v << K;
      quo_v = {quo_v[NUM_W-K-1:0], dig_v};
    end
    num_nxt = num_v;
    quo_nxt = quo_v;
    rem_nxt = rem_v;
  end

  assign mag     = diff_r[DIFF_W-1] ? (~diff_r + 1'b1) : diff_r;
  assign quo_mag = quo_r[VAL_W-1:0];
  assign sum     = neg_r ? ({{2{acc_r[VAL_W-1]}}, acc_r} - {2'b00, quo_mag})
                         : ({{2{acc_r[VAL_W-1]}}, acc_r} + {2'b00, quo_mag});
  assign ovf     = (sum[SUM_W-1] != sum[VAL_W-1]) || (sum[SUM_W-2] != sum[VAL_W-1]);

  always_ff @(posedge clk) begin
    if (ctl.load) prev_r <= col_in;
    case (state_r)
      CS_IDLE: begin
        if (ctl.load && ctl.run) begin
          acc_r  <= col_in;
          diff_r <= {col_in[VAL_W-1], col_in} - {prev_r[VAL_W-1], prev_r};
        end
      end
      CS_ABS: begin
        neg_r <= diff_r[DIFF_W-1];
        num_r <= NUM_W'(mag[VAL_W-1:0]);
        quo_r <= '0;
        rem_r <= '0;
        cnt_r <= '0;
      end
      CS_DIV: begin
        num_r <= num_nxt;
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
      end
      CS_ADD: begin
        sat_r <= ovf;
        val_r <= ovf ? (sum[SUM_W-1] ? VAL_MIN : VAL_MAX) : sum[VAL_W-1:0];
      end
      default: ;
    endcase
  end

  assign res = '{done: (state_r == CS_DONE), sat: sat_r, value: val_r};

  `ASSERT_NEVER(a_rem_below_div, clk, rst_n, (state_r == CS_DIV) && (rem_r == DIV))
  `ASSERT_NEVER(a_take_when_done, clk, rst_n, ctl.take && (state_r != CS_DONE))
  `ASSERT_NEVER(a_run_when_idle, clk, rst_n, ctl.run && (state_r != CS_IDLE))

endmodule

[rtl/core/richardson_extrapolation_table.sv]
// ----------------------------------------------------------------------------
// richardson_extrapolation_table
// Richardson tableau, one row per estimate request, one entry per result.
// ----------------------------------------------------------------------------
// Use: in_ch takes one request (base_estimate in signed Q24.24, restart).
// Level m of a table (m = 0 after restart, after reset or after MAX_LEVEL
// rows) returns m+1 entries on out_ch, columns 0..m, last set on column m.
// Column 0 is held in the column-0 register once the request is taken
// and moves to the output register when that is free. Each later column k
// is made by cell k after column k-1 is taken: the cell forms the difference
// to its previous-row entry, takes its magnitude, divides it by 2^k-1 with
// an iterative recurrence, then adds and saturates. Rows are worked one at
// a time.
// in_ch.ready rises again in the cycle after the last column of a row has
// moved into the output register, so the next request overlaps the wait
// for that entry to be taken. A stalled receiver holds the output register
// and freezes the chain: the finished cell keeps its entry until taken.
// Reset clears the level counter and all control state; the stored previous
// row is not cleared, since a row only reads entries the row before wrote.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module richardson_extrapolation_table import rext_pkg::*; #(
  parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
  input logic        clk,
  input logic        rst_n,
  rext_in_if.sink    in_ch,
  rext_out_if.source out_ch
);

  localparam logic [LVL_W:0] LVL_LIMIT = (LVL_W + 1)'(MAX_LEVEL);

  // Control
  logic             busy_r;      // a row is in flight
  logic             s0_pend_r;   // column 0 waits for the output register
  logic [LVL_W-1:0] cur_lvl_r;   // level of the next request
  logic [LVL_W-1:0] lvl_r;       // level of the row in flight
  logic [LVL_W-1:0] col_r;       // next column to emit
  logic             out_valid_r;

  // Payload
  val_t                 s0_val_r;
  logic [OUT_IDX_W-1:0] out_level_r;
  logic [OUT_IDX_W-1:0] out_column_r;
  val_t                 out_value_r;
  logic                 out_sat_r;
  logic                 out_last_r;

  logic             accept;
  logic             slot_free;
  logic             take;
  logic             last;
  logic [LVL_W-1:0] new_lvl;

  // Stage 0 is the column-0 register here; stages 1.. are the cells.
  cell_res_t            cres [MAX_LEVEL];
  cell_ctl_t            cctl [1:MAX_LEVEL-1];
  logic [MAX_LEVEL-1:0] stage_done;
  val_t                 sel_val;
  logic                 sel_sat;

  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && !busy_r;

  // Restart or a full table starts over at level zero.
  assign new_lvl = (in_ch.restart || ({1'b0, cur_lvl_r} >= LVL_LIMIT)) ? '0 : cur_lvl_r;

  assign last      = (col_r == lvl_r);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign take      = (|stage_done) && slot_free;

  assign cres[0] = '{done: s0_pend_r, sat: 1'b0, value: s0_val_r};

  // Chain: a taken entry is handed to the next cell, which stores it as its
  // previous-row entry and, unless the row ends, computes the next column.
  for (genvar j = 1; j < MAX_LEVEL; j++) begin : g_cell
    assign cctl[j] = '{load: take && stage_done[j-1],
                       run:  take && stage_done[j-1] && !last,
                       take: take && stage_done[j]};

    rext_cell #(.K(j)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .col_in (cres[j-1].value),
      .ctl    (cctl[j]),
      .res    (cres[j])
    );
  end

  for (genvar j = 0; j < MAX_LEVEL; j++) begin : g_done
    assign stage_done[j] = cres[j].done;
  end

  // At most one stage is done at a time, so an OR picks its entry.
  always_comb begin
    sel_val = '0;
    sel_sat = 1'b0;
    for (int j = 0; j < MAX_LEVEL; j++) begin
      sel_val = sel_val | (stage_done[j] ? cres[j].value : '0);
      sel_sat = sel_sat | (stage_done[j] && cres[j].sat);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      s0_pend_r   <= 1'b0;
      cur_lvl_r   <= '0;
      lvl_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r    <= 1'b1;
        s0_pend_r <= 1'b1;
        lvl_r     <= new_lvl;
        cur_lvl_r <= new_lvl + 1'b1;
        col_r     <= '0;
      end else if (take) begin
        col_r <= col_r + 1'b1;
        if (last) busy_r <= 1'b0;
        if (stage_done[0]) s0_pend_r <= 1'b0;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s0_val_r <= in_ch.base_estimate;
    if (take) begin
      out_level_r  <= lvl_r[OUT_IDX_W-1:0];
      out_column_r <= col_r[OUT_IDX_W-1:0];
      out_value_r  <= sel_val;
      out_sat_r    <= sel_sat;
      out_last_r   <= last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.level     = out_level_r;
  assign out_ch.column    = out_column_r;
  assign out_ch.value     = out_value_r;
  assign out_ch.saturated = out_sat_r;
  assign out_ch.last      = out_last_r;

  `ASSERT_CLK(a_one_stage_done, clk, rst_n, $onehot0(stage_done))
  `ASSERT_CLK(a_idle_no_pending, clk, rst_n, !busy_r |-> (stage_done == '0))
  `ASSERT_CLK(a_row_end_frees, clk, rst_n, (take && last) |=> !busy_r)

endmodule
